### src/flvab_pkg.sv
// flvab_pkg: shared types and constants for the flv video tag to annex b converter
// no dependencies; imported by the parser and the top level
`timescale 1ns / 1ps

package flvab_pkg;

	// parser phases
	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_KIND     = 3'd1,
		PH_NALU_HDR = 3'd2,
		PH_SPS_HDR  = 3'd3,
		PH_DATA     = 3'd4,
		PH_PPS_HDR  = 3'd5,
		PH_SKIP     = 3'd6
	} flvab_phase_t;

	// unit kinds as seen on the output
	localparam logic [1:0] KIND_SPS   = 2'd0;
	localparam logic [1:0] KIND_PPS   = 2'd1;
	localparam logic [1:0] KIND_KEY   = 2'd2;
	localparam logic [1:0] KIND_INTER = 2'd3;

	// tag type bytes
	localparam logic [7:0] TAG_KEY_FRAME   = 8'h17;
	localparam logic [7:0] TAG_INTER_FRAME = 8'h27;
	localparam logic [7:0] PKT_SEQ_HEADER  = 8'h00;
	localparam logic [7:0] PKT_NALU        = 8'h01;

	// header byte positions
	localparam logic [3:0] NALU_LEN_FIRST = 4'd5;
	localparam logic [3:0] NALU_HDR_LAST  = 4'd8;
	localparam logic [3:0] SPS_LEN_FIRST  = 4'd11;
	localparam logic [3:0] SEQ_HDR_LAST   = 4'd12;
	localparam logic [3:0] PPS_LEN_FIRST  = 4'd1;
	localparam logic [3:0] PPS_HDR_LAST   = 4'd2;

	// start code bytes
	localparam logic [7:0] SC_ZERO = 8'h00;
	localparam logic [7:0] SC_ONE  = 8'h01;
	localparam logic [2:0] SC_LEN  = 3'd4;

	// what one accepted byte produces
	typedef struct packed {
		logic       valid;     // at least one result
		logic       start;     // four start code bytes rather than one payload byte
		logic [7:0] data;      // payload byte
		logic [1:0] kind;
	} flvab_emit_t;

endpackage

### src/flvab_tag_if.sv
// flvab_tag_if: input channel carrying tag body bytes
// depends on nothing
`timescale 1ns / 1ps

interface flvab_tag_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_tag;

	modport source(output valid, output in_byte, output end_of_tag, input ready);
	modport sink(input valid, input in_byte, input end_of_tag, output ready);
endinterface

### src/flvab_annexb_if.sv
// flvab_annexb_if: output channel carrying annex b stream bytes
// depends on nothing
`timescale 1ns / 1ps

interface flvab_annexb_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] unit_kind;
	logic       is_start_code;
	logic       last_of_run;

	modport source(output valid, output out_byte, output unit_kind, output is_start_code,
		output last_of_run, input ready);
	modport sink(input valid, input out_byte, input unit_kind, input is_start_code,
		input last_of_run, output ready);
endinterface

### src/flv_video_tag_to_annexb_unit.sv
// flv_video_tag_to_annexb_unit: top level of the flv avc tag to annex b converter
// depends on flvab_pkg, flvab_tag_if, flvab_annexb_if and flvab_parser
`timescale 1ns / 1ps

// usage
// tag channel: one byte of an flv video tag body per transfer, end_of_tag on the
//   last byte; the parser then goes back to waiting for the next tag
// annexb channel: the annex b stream; each byte tagged with its unit kind, a start
//   code flag and last_of_run on the final byte caused by one input transfer
// output: a result byte is registered and appears in the cycle after the input transfer that causes it
// throughput: one input byte per cycle for header and payload bytes while annexb is
//   ready; a byte that completes a length field yields the four byte start code, so
//   input is held until the final start code byte leaves the output register
// the output register is loaded in the same cycle that its last byte leaves, so a
//   ready receiver gets a steady stream of payload bytes at one per cycle, no bubbles
// ready on the tag side looks at the output register occupancy and annexb ready
// reset: parser back to idle, output register empty, nothing pending
// receiver stall: the output register holds its byte and the tag side stops
//   taking bytes once the register is full; nothing is lost or repeated
// bytes past the declared length and unknown tags are taken and dropped

module flv_video_tag_to_annexb_unit (
	input  logic           clk,
	input  logic           arst_n,
	flvab_tag_if.sink      tag,
	flvab_annexb_if.source annexb
);
	import flvab_pkg::*;

	flvab_emit_t emit;
	logic        in_xfer;
	logic        out_xfer;

	// output register: count of bytes still to send from this run
	logic [2:0]  cnt_q;
	logic        sc_q;
	logic [7:0]  byte_q;
	logic [1:0]  kind_q;

	assign out_xfer  = annexb.valid && annexb.ready;
	// free when empty, or when its last byte leaves this cycle
	assign tag.ready = (cnt_q == 3'd0) || (cnt_q == 3'd1 && annexb.ready);
	assign in_xfer   = tag.valid && tag.ready;

	flvab_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_xfer),
		.in_byte    (tag.in_byte),
		.end_of_tag (tag.end_of_tag),
		.emit       (emit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sc_q  <= 1'b0;
		end else if (in_xfer) begin
			// a byte with no result leaves the register empty
			if (emit.valid)
				cnt_q <= emit.start ? SC_LEN : 3'd1;
			else
				cnt_q <= '0;
			sc_q <= emit.start;
		end else if (out_xfer) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	// payload of the output register
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_q <= emit.data;
			kind_q <= emit.kind;
		end
	end

	assign annexb.valid         = (cnt_q != 3'd0);
	assign annexb.is_start_code = sc_q;
	assign annexb.last_of_run   = (cnt_q == 3'd1);
	assign annexb.unit_kind     = kind_q;
	// start code runs 00 00 00 01, the last byte being the one
	assign annexb.out_byte      = sc_q ? ((cnt_q == 3'd1) ? SC_ONE : SC_ZERO) : byte_q;

endmodule

### src/flvab_parser.sv
// flvab_parser: tag header parser state and per byte result decision
// depends on flvab_pkg
`timescale 1ns / 1ps

module flvab_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic [7:0]             in_byte,
	input  logic                   end_of_tag,
	output flvab_pkg::flvab_emit_t emit
);
	import flvab_pkg::*;

	flvab_phase_t phase_q, phase_d;
	logic [3:0]   hpos_q, hpos_d;
	logic [1:0]   kind_q, kind_d;
	logic [7:0]   first_q, first_d;
	logic [31:0]  remain_q, remain_d;

	// next state
	always_comb begin
		logic [31:0] len;
		logic        open_unit;
		len       = remain_q;
		open_unit = 1'b0;
		phase_d   = phase_q;
		hpos_d    = hpos_q;
		kind_d    = kind_q;
		first_d   = first_q;
		remain_d  = remain_q;
		case (phase_q)
			PH_IDLE: begin
				first_d = in_byte;
				hpos_d  = 4'd1;
				phase_d = PH_KIND;
			end
			PH_KIND: begin
				remain_d = '0;
				hpos_d   = 4'd2;
				if (first_q == TAG_KEY_FRAME && in_byte == PKT_SEQ_HEADER) begin
					kind_d  = KIND_SPS;
					phase_d = PH_SPS_HDR;
				end else if (first_q == TAG_KEY_FRAME && in_byte == PKT_NALU) begin
					kind_d  = KIND_KEY;
					phase_d = PH_NALU_HDR;
				end else if (first_q == TAG_INTER_FRAME && in_byte == PKT_NALU) begin
					kind_d  = KIND_INTER;
					phase_d = PH_NALU_HDR;
				end else begin
					phase_d = PH_SKIP;
				end
			end
			PH_NALU_HDR: begin
				if (hpos_q >= NALU_LEN_FIRST)
					len = {remain_q[23:0], in_byte};
				if (hpos_q >= NALU_HDR_LAST)
					open_unit = 1'b1;
				else
					hpos_d = hpos_q + 4'd1;
				remain_d = len;
			end
			PH_SPS_HDR: begin
				if (hpos_q >= SPS_LEN_FIRST)
					len = {16'd0, remain_q[7:0], in_byte};
				if (hpos_q >= SEQ_HDR_LAST)
					open_unit = 1'b1;
				else
					hpos_d = hpos_q + 4'd1;
				remain_d = len;
			end
			PH_PPS_HDR: begin
				if (hpos_q >= PPS_LEN_FIRST)
					len = {16'd0, remain_q[7:0], in_byte};
				if (hpos_q >= PPS_HDR_LAST)
					open_unit = 1'b1;
				else
					hpos_d = hpos_q + 4'd1;
				remain_d = len;
			end
			PH_DATA: begin
				remain_d = remain_q - 32'd1;
				if (remain_d == '0) begin
					if (kind_q == KIND_SPS) begin
						phase_d = PH_PPS_HDR;
						kind_d  = KIND_PPS;
						hpos_d  = '0;
					end else begin
						phase_d = PH_SKIP;
					end
				end
			end
			default: begin
			end
		endcase
		if (open_unit) begin
			if (len != '0) begin
				phase_d = PH_DATA;
			end else if (kind_q == KIND_SPS) begin
				phase_d  = PH_PPS_HDR;
				kind_d   = KIND_PPS;
				hpos_d   = '0;
				remain_d = '0;
			end else begin
				phase_d = PH_SKIP;
			end
		end
		if (end_of_tag) begin
			phase_d  = PH_IDLE;
			hpos_d   = '0;
			remain_d = '0;
		end
	end

	// result of the current byte; start code carries the kind before any switch to pps
	always_comb begin
		emit.valid = 1'b0;
		emit.start = 1'b0;
		emit.data  = in_byte;
		emit.kind  = kind_q;
		case (phase_q)
			PH_NALU_HDR: begin
				emit.start = (hpos_q >= NALU_HDR_LAST);
				emit.valid = emit.start;
			end
			PH_SPS_HDR: begin
				emit.start = (hpos_q >= SEQ_HDR_LAST);
				emit.valid = emit.start;
			end
			PH_PPS_HDR: begin
				emit.start = (hpos_q >= PPS_HDR_LAST);
				emit.valid = emit.start;
			end
			PH_DATA: begin
				emit.valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			hpos_q   <= '0;
			kind_q   <= '0;
			first_q  <= '0;
			remain_q <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			hpos_q   <= hpos_d;
			kind_q   <= kind_d;
			first_q  <= first_d;
			remain_q <= remain_d;
		end
	end

endmodule

### src/flvab_checker.sv
// flvab_checker: port level assertions for the converter, bound to the top level
// depends on flv_video_tag_to_annexb_unit
`timescale 1ns / 1ps

module flvab_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic [1:0] unit_kind,
	input logic       is_start_code,
	input logic       last_of_run
);

	// stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// start code closes with 01
	a_sc_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_start_code && last_of_run |-> out_byte == 8'h01)
		else $error("start code does not end in 01");

	// start code leading bytes are zero
	a_sc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_start_code && !last_of_run |-> out_byte == 8'h00)
		else $error("start code leading byte not zero");

	// a payload byte is a run of its own
	a_data_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_start_code |-> last_of_run)
		else $error("payload byte not last of its run");

	// a run continues without gap and with the same kind
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=>
			out_valid && is_start_code && $stable(unit_kind))
		else $error("start code run broken");

endmodule

bind flv_video_tag_to_annexb_unit flvab_checker u_flvab_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (annexb.valid),
	.out_ready     (annexb.ready),
	.out_byte      (annexb.out_byte),
	.unit_kind     (annexb.unit_kind),
	.is_start_code (annexb.is_start_code),
	.last_of_run   (annexb.last_of_run)
);
